[rtl/spectrum_peak_hold_bands_core_macros.svh]
`ifndef SPECTRUM_PEAK_HOLD_BANDS_CORE_MACROS_SVH
`define SPECTRUM_PEAK_HOLD_BANDS_CORE_MACROS_SVH

// Assertion shorthands. They expect clk and rst_n in the scope of use.

// The consequent must hold in the same cycle as the antecedent.
`define SPHB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPHB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sphb_pkg.sv]
package sphb_pkg;

  // Array sizes.
  localparam int NUM_BINS   = 256;
  localparam int NUM_BANDS  = 6;
  localparam int BAND_WIDTH = 51;

  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int BAND_IDX_W = $clog2(NUM_BANDS);

  // Field widths.
  localparam int IDX_W      = 8;
  localparam int MAG_W      = 16;
  localparam int LVL_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int DECAY_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Weighting arithmetic: magnitude * (100 + 9*bin) * gain / 25600.
  localparam int TILT_BASE    = 100;
  localparam int TILT_SLOPE   = 9;
  localparam int TILT_W       = 12;
  localparam int P1_W         = MAG_W + TILT_W;
  localparam int P2_W         = P1_W + GAIN_W;
  localparam int SCALE_SHIFT  = 8;
  localparam int X_W          = P2_W - SCALE_SHIFT;
  localparam int DIV_LO       = 100;
  localparam int FULL_SCALE   = 32768;
  localparam int SAT_X        = DIV_LO * FULL_SCALE;
  localparam int XL_W         = 22;
  localparam int RECIP_SHIFT  = 29;
  localparam int RECIP_M      = ((1 << RECIP_SHIFT) + DIV_LO - 1) / DIV_LO;
  localparam int RECIP_W      = 23;
  localparam int P3_W         = XL_W + RECIP_W;

  localparam logic [LVL_W-1:0]      LEVEL_ONE   = LVL_W'(FULL_SCALE);
  localparam logic [GAIN_W-1:0]     GAIN_RESET  = GAIN_W'(256);
  localparam logic [DECAY_W-1:0]    DECAY_RESET = DECAY_W'(1311);
  localparam logic [BAND_IDX_W-1:0] LAST_BAND   = BAND_IDX_W'(NUM_BANDS - 1);

  // Result kinds.
  localparam logic KIND_BIN  = 1'b0;
  localparam logic KIND_BAND = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = CFG_IDX_W'(1);

  // Control from the update stage to the band peak unit.
  typedef struct packed {
    logic                  upd;
    logic [IDX_W-1:0]      bin;
    logic [LVL_W-1:0]      lvl;
    logic                  clr;
    logic [BAND_IDX_W-1:0] sel;
  } band_ctl_t;

endpackage

[rtl/sphb_in_if.sv]
interface sphb_in_if;
  logic                        valid;
  logic                        ready;
  logic [sphb_pkg::IDX_W-1:0]  bin_index;
  logic [sphb_pkg::MAG_W-1:0]  magnitude;

  modport source (output valid, output bin_index, output magnitude, input ready);
  modport sink (input valid, input bin_index, input magnitude, output ready);
endinterface

[rtl/sphb_out_if.sv]
interface sphb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [sphb_pkg::IDX_W-1:0]  index;
  logic [sphb_pkg::LVL_W-1:0]  level;
  logic                        last;

  modport source (output valid, output kind, output index, output level, output last,
                  input ready);
  modport sink (input valid, input kind, input index, input level, input last,
                output ready);
endinterface

[rtl/sphb_ram.sv]
module sphb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sphb_weight.sv]
module sphb_weight (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_v,
  input  logic [sphb_pkg::IDX_W-1:0]     in_bin,
  input  logic [sphb_pkg::MAG_W-1:0]     in_mag,
  input  logic [sphb_pkg::GAIN_W-1:0]    gain,
  output logic                           out_v,
  output logic [sphb_pkg::IDX_W-1:0]     out_bin,
  output logic [sphb_pkg::LVL_W-1:0]     weighted
);

  logic [sphb_pkg::TILT_W-1:0]  tilt;
  logic [sphb_pkg::X_W-1:0]     x;
  logic                         sat;

  logic                         v1_r, v2_r, v3_r;
  logic [sphb_pkg::IDX_W-1:0]   bin1_r, bin2_r, bin3_r;
  logic [sphb_pkg::P1_W-1:0]    p1_r;
  logic [sphb_pkg::P2_W-1:0]    p2_r;
  logic [sphb_pkg::P3_W-1:0]    p3_r;
  logic                         sat3_r;

  // Spectral tilt factor, 100 + 9*bin.
  assign tilt = sphb_pkg::TILT_W'(sphb_pkg::TILT_BASE)
              + sphb_pkg::TILT_W'(sphb_pkg::TILT_SLOPE) * sphb_pkg::TILT_W'(in_bin);

  // Drop the /256 part of the divisor; the /100 part is a reciprocal multiply
  // that is exact below the saturation point.
  assign x   = p2_r[sphb_pkg::P2_W-1:sphb_pkg::SCALE_SHIFT];
  assign sat = (x >= sphb_pkg::X_W'(sphb_pkg::SAT_X));

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Product stages.
  always_ff @(posedge clk) begin
    if (en) begin
      bin1_r <= in_bin;
      p1_r   <= sphb_pkg::P1_W'(in_mag) * sphb_pkg::P1_W'(tilt);
      bin2_r <= bin1_r;
      p2_r   <= sphb_pkg::P2_W'(p1_r) * sphb_pkg::P2_W'(gain);
      bin3_r <= bin2_r;
      sat3_r <= sat;
      p3_r   <= sphb_pkg::P3_W'(x[sphb_pkg::XL_W-1:0])
              * sphb_pkg::P3_W'(sphb_pkg::RECIP_M);
    end
  end

  assign out_v    = v3_r;
  assign out_bin  = bin3_r;
  assign weighted = sat3_r ? sphb_pkg::LEVEL_ONE
                           : p3_r[sphb_pkg::RECIP_SHIFT +: sphb_pkg::LVL_W];

endmodule

[rtl/sphb_bands.sv]
module sphb_bands (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sphb_pkg::band_ctl_t         ctl,
  output logic [sphb_pkg::LVL_W-1:0]  peak
);

  logic [sphb_pkg::LVL_W-1:0]      peak_r [sphb_pkg::NUM_BANDS];
  logic [sphb_pkg::NUM_BANDS-1:0]  hit;
  logic [31:0]                     bin32;

  assign bin32 = 32'(ctl.bin);

  // Band membership: band 0 spans all bins but the last, the others are slices.
  always_comb begin
    for (int k = 0; k < sphb_pkg::NUM_BANDS; k++) begin
      if (k == 0) begin
        hit[k] = (bin32 < 32'(sphb_pkg::NUM_BINS - 1));
      end else begin
        hit[k] = (bin32 >= 32'(sphb_pkg::BAND_WIDTH * (k - 1)))
              && (bin32 < 32'(sphb_pkg::BAND_WIDTH * k));
      end
    end
  end

  // Peak tracking; a band is cleared as its result is sent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < sphb_pkg::NUM_BANDS; k++) begin
        peak_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < sphb_pkg::NUM_BANDS; k++) begin
        if (ctl.clr && ctl.sel == sphb_pkg::BAND_IDX_W'(k)) begin
          peak_r[k] <= '0;
        end else if (ctl.upd && hit[k] && ctl.lvl > peak_r[k]) begin
          peak_r[k] <= ctl.lvl;
        end
      end
    end
  end

  // Selected band for the result stream.
  always_comb begin
    peak = '0;
    for (int k = 0; k < sphb_pkg::NUM_BANDS; k++) begin
      if (ctl.sel == sphb_pkg::BAND_IDX_W'(k)) begin
        peak = peak_r[k];
      end
    end
  end

endmodule

[rtl/spectrum_peak_hold_bands_core.sv]
// Peak-hold spectrum meter: each accepted item (bin number, Q1.15 magnitude) is weighted
// by the tilt (100+9*bin)/100 and the Q8.8 gain, saturated at 1.0, and merged into the
// bin's stored level (rise at once, otherwise fall by decay_step but not below the new
// value); the item returns the bin's new level. Bin 255 is followed by six band maxima,
// band 0 first, the last with last set, after which the band maxima restart from zero.
// Bin results carry last set except for bin 255. Items out of the bin range are taken and
// give nothing. The block takes one item per cycle while results are taken and no band
// results are being sent; an item passes three multiply stages, the update stage with the
// bin memory read and the output register before its result is offered. At the end of
// each frame the six band results are sent, during which the update stage holds. Bin
// levels live in a 256 x 16 memory read, updated and written back with forwarding between
// back-to-back items of the same bin; a valid bit per entry makes it read as zero after
// reset, so no clearing pass is needed. Configuration writes take effect on the next
// clock edge.
`include "spectrum_peak_hold_bands_core_macros.svh"

module spectrum_peak_hold_bands_core (
  input  logic                              clk,
  input  logic                              rst_n,
  sphb_in_if.sink                           in_ch,
  sphb_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [sphb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sphb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [sphb_pkg::GAIN_W-1:0]       gain_r;
  logic [sphb_pkg::DECAY_W-1:0]      decay_r;

  logic                              adv;
  logic                              retire;
  logic                              out_free;
  logic                              in_take;

  logic                              w_v;
  logic [sphb_pkg::IDX_W-1:0]        w_bin;
  logic [sphb_pkg::LVL_W-1:0]        w_lvl;

  logic                              v4_r;
  logic [sphb_pkg::IDX_W-1:0]        bin4_r;
  logic [sphb_pkg::LVL_W-1:0]        w4_r;
  logic                              vld_rd_r;
  logic                              hit_r;
  logic [sphb_pkg::LVL_W-1:0]        fwd_lvl_r;
  logic [sphb_pkg::NUM_BINS-1:0]     bin_valid_r;
  logic [sphb_pkg::LVL_W-1:0]        ram_rdata;

  logic [sphb_pkg::LVL_W-1:0]        old_lvl;
  logic [sphb_pkg::LVL_W:0]          diff;
  logic [sphb_pkg::LVL_W-1:0]        new_lvl;
  logic                              last_bin4;

  logic                              drain_r;
  logic [sphb_pkg::BAND_IDX_W-1:0]   band_cnt_r;
  logic                              band_load;
  logic [sphb_pkg::LVL_W-1:0]        band_peak;
  sphb_pkg::band_ctl_t               band_ctl;

  logic                              out_v_r;
  logic                              out_kind_r;
  logic [sphb_pkg::IDX_W-1:0]        out_index_r;
  logic [sphb_pkg::LVL_W-1:0]        out_level_r;
  logic                              out_last_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= sphb_pkg::GAIN_RESET;
      decay_r <= sphb_pkg::DECAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sphb_pkg::CFG_GAIN:  gain_r  <= sphb_pkg::GAIN_W'(cfg_wdata);
        sphb_pkg::CFG_DECAY: decay_r <= sphb_pkg::DECAY_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Pipeline control: everything moves unless the update stage holds an item
  // that cannot hand its result over.
  assign out_free = !out_v_r || out_ch.ready;
  assign retire   = v4_r && out_free && !drain_r;
  assign adv      = !v4_r || retire;
  assign in_take  = in_ch.valid && adv
                 && (32'(in_ch.bin_index) < 32'(sphb_pkg::NUM_BINS));
  assign in_ch.ready = adv;

  sphb_weight u_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (in_take),
    .in_bin   (in_ch.bin_index),
    .in_mag   (in_ch.magnitude),
    .gain     (gain_r),
    .out_v    (w_v),
    .out_bin  (w_bin),
    .weighted (w_lvl)
  );

  sphb_ram #(
    .WIDTH (sphb_pkg::LVL_W),
    .DEPTH (sphb_pkg::NUM_BINS)
  ) u_level_ram (
    .clk   (clk),
    .we    (retire),
    .waddr (sphb_pkg::BIN_W'(bin4_r)),
    .wdata (new_lvl),
    .re    (adv),
    .raddr (sphb_pkg::BIN_W'(w_bin)),
    .rdata (ram_rdata)
  );

  // Update stage registers; the memory read is issued as the item enters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r  <= 1'b0;
      hit_r <= 1'b0;
    end else if (adv) begin
      v4_r  <= w_v;
      hit_r <= retire && w_v && (w_bin == bin4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bin4_r    <= w_bin;
      w4_r      <= w_lvl;
      vld_rd_r  <= bin_valid_r[sphb_pkg::BIN_W'(w_bin)];
      fwd_lvl_r <= new_lvl;
    end
  end

  // Entries read as zero until first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_valid_r <= '0;
    end else if (retire) begin
      bin_valid_r[sphb_pkg::BIN_W'(bin4_r)] <= 1'b1;
    end
  end

  // Level update: rise to the weighted value or decay, never below it.
  assign old_lvl = hit_r ? fwd_lvl_r : (vld_rd_r ? ram_rdata : '0);
  assign diff    = {1'b0, old_lvl} - {1'b0, decay_r};
  assign new_lvl = ((w4_r > old_lvl) || diff[sphb_pkg::LVL_W]
                    || (diff[sphb_pkg::LVL_W-1:0] < w4_r))
                   ? w4_r : diff[sphb_pkg::LVL_W-1:0];
  assign last_bin4 = (32'(bin4_r) == 32'(sphb_pkg::NUM_BINS - 1));

  // Band results are sent one per free output slot after the last bin.
  assign band_load = drain_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r    <= 1'b0;
      band_cnt_r <= '0;
    end else if (retire && last_bin4) begin
      drain_r    <= 1'b1;
      band_cnt_r <= '0;
    end else if (band_load) begin
      if (band_cnt_r == sphb_pkg::LAST_BAND) begin
        drain_r <= 1'b0;
      end else begin
        band_cnt_r <= band_cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    band_ctl.upd = retire;
    band_ctl.bin = bin4_r;
    band_ctl.lvl = new_lvl;
    band_ctl.clr = band_load;
    band_ctl.sel = band_cnt_r;
  end

  sphb_bands u_bands (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (band_ctl),
    .peak  (band_peak)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (retire || band_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_kind_r  <= sphb_pkg::KIND_BIN;
      out_index_r <= bin4_r;
      out_level_r <= new_lvl;
      out_last_r  <= !last_bin4;
    end else if (band_load) begin
      out_kind_r  <= sphb_pkg::KIND_BAND;
      out_index_r <= sphb_pkg::IDX_W'(band_cnt_r);
      out_level_r <= band_peak;
      out_last_r  <= (band_cnt_r == sphb_pkg::LAST_BAND);
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.index = out_index_r;
  assign out_ch.level = out_level_r;
  assign out_ch.last  = out_last_r;

  // Checks.
  `SPHB_ASSERT_NOW(a_level_cap, out_v_r, out_level_r <= sphb_pkg::LEVEL_ONE, "level over one")
  `SPHB_ASSERT_NOW(a_fwd_item, hit_r, v4_r, "forwarded level without an item")
  `SPHB_ASSERT_NEXT(a_drain_start, retire && last_bin4, drain_r && band_cnt_r == '0, "no bands")
  `SPHB_ASSERT_NEXT(a_drain_end, band_load && band_cnt_r == sphb_pkg::LAST_BAND, !drain_r, "no end")

endmodule

[dv/spectrum_peak_hold_bands_core_test.sv]
`timescale 1ns / 1ps

module spectrum_peak_hold_bands_core_test;

  localparam int WEIGHT_DIV    = 25600;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 45;
  localparam int LONG_HOLD     = 80;
  localparam int MAX_REPORTS   = 100;

  // One result item as the block sends it.
  typedef struct {
    logic                       kind;
    logic [sphb_pkg::IDX_W-1:0] index;
    logic [sphb_pkg::LVL_W-1:0] level;
    logic                       last;
  } meter_result_t;

  // Keeps its own copy of the meter state and the queue of levels still to come.
  class peak_meter_board;
    logic [sphb_pkg::GAIN_W-1:0]  gain;
    logic [sphb_pkg::DECAY_W-1:0] decay_step;
    logic [sphb_pkg::LVL_W-1:0]   bin_level [sphb_pkg::NUM_BINS];
    logic [sphb_pkg::LVL_W-1:0]   band_peak [sphb_pkg::NUM_BANDS];
    meter_result_t                expected_levels [$];
    int                           errors;

    function new();
      gain = sphb_pkg::GAIN_RESET;
      decay_step = sphb_pkg::DECAY_RESET;
      foreach (bin_level[i]) bin_level[i] = '0;
      foreach (band_peak[i]) band_peak[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [sphb_pkg::CFG_IDX_W-1:0] idx,
                            logic [sphb_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        sphb_pkg::CFG_GAIN: begin
          gain = value;
        end
        sphb_pkg::CFG_DECAY: begin
          decay_step = value;
        end
        default: begin
        end
      endcase
    endfunction

    // Weights the magnitude, merges it into the bin level and queues the results.
    function void note_item(logic [sphb_pkg::IDX_W-1:0] bin,
                            logic [sphb_pkg::MAG_W-1:0] magnitude);
      longint                     prod;
      longint                     fallen;
      logic [sphb_pkg::LVL_W-1:0] weighted;
      logic [sphb_pkg::LVL_W-1:0] lvl;
      int                         band;
      prod = longint'(magnitude)
             * longint'(sphb_pkg::TILT_BASE + sphb_pkg::TILT_SLOPE * int'(bin))
             * longint'(gain) / WEIGHT_DIV;
      weighted = (prod > sphb_pkg::FULL_SCALE) ? sphb_pkg::LEVEL_ONE
                                                : sphb_pkg::LVL_W'(prod);
      lvl = bin_level[bin];
      if (weighted > lvl) begin
        lvl = weighted;
      end else begin
        fallen = longint'(lvl) - longint'(decay_step);
        if (fallen < longint'(weighted)) fallen = longint'(weighted);
        lvl = sphb_pkg::LVL_W'(fallen);
      end
      bin_level[bin] = lvl;

      // The last bin belongs to no band.
      if (int'(bin) < sphb_pkg::NUM_BINS - 1) begin
        band = int'(bin) / sphb_pkg::BAND_WIDTH + 1;
        if (lvl > band_peak[0]) band_peak[0] = lvl;
        if (band < sphb_pkg::NUM_BANDS && lvl > band_peak[band]) band_peak[band] = lvl;
        expected_levels.push_back('{sphb_pkg::KIND_BIN, bin, lvl, 1'b1});
      end else begin
        expected_levels.push_back('{sphb_pkg::KIND_BIN, bin, lvl, 1'b0});
        for (int b = 0; b < sphb_pkg::NUM_BANDS; b++) begin
          expected_levels.push_back('{sphb_pkg::KIND_BAND, sphb_pkg::IDX_W'(b),
                                      band_peak[b], b == sphb_pkg::NUM_BANDS - 1});
          band_peak[b] = '0;
        end
      end
    endfunction

    function void report(string field, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_result(meter_result_t got);
      meter_result_t want;
      if (expected_levels.size() == 0) begin
        report("unexpected result, level", -1, got.level);
        return;
      end
      want = expected_levels.pop_front();
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.index !== want.index) report("index", want.index, got.index);
      if (got.level !== want.level) report("level", want.level, got.level);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [sphb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sphb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sphb_in_if  in_ch ();
  sphb_out_if out_ch ();

  peak_meter_board board;
  meter_result_t   seen_result;
  int              gap_pct;
  int              stall_pct;
  int              long_hold_req;
  int              quiet_cycles;
  int              items_sent;
  int              frames_sent;

  spectrum_peak_hold_bands_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Both channels are sampled at the rising edge; the idle counter feeds the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_item(in_ch.bin_index, in_ch.magnitude);
      if (out_ch.valid && out_ch.ready) begin
        seen_result = '{out_ch.kind, out_ch.index, out_ch.level, out_ch.last};
        board.check_result(seen_result);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req > 0) begin
        hold = long_hold_req;
        long_hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Magnitudes cluster around the point where this bin saturates at unit gain.
  function automatic int pick_magnitude(int bin);
    int knee;
    knee = sphb_pkg::FULL_SCALE * sphb_pkg::TILT_BASE
           / (sphb_pkg::TILT_BASE + sphb_pkg::TILT_SLOPE * bin);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      3, 4: return $urandom_range(0, knee + knee / 4);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // Offers one item, with an optional gap before it, and returns at the falling edge
  // after it was taken.
  task automatic send_bin(int bin, int magnitude);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.bin_index <= sphb_pkg::IDX_W'(bin);
    in_ch.magnitude <= sphb_pkg::MAG_W'(magnitude);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (bin == sphb_pkg::NUM_BINS - 1) frames_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_regs(int gain, int decay);
    cfg_we <= 1'b1;
    cfg_index <= sphb_pkg::CFG_GAIN;
    cfg_wdata <= sphb_pkg::CFG_DATA_W'(gain);
    @(negedge clk);
    cfg_index <= sphb_pkg::CFG_DECAY;
    cfg_wdata <= sphb_pkg::CFG_DATA_W'(decay);
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(sphb_pkg::CFG_GAIN, sphb_pkg::CFG_DATA_W'(gain));
    board.write_reg(sphb_pkg::CFG_DECAY, sphb_pkg::CFG_DATA_W'(decay));
  endtask

  // Mostly ascending runs that close the frame, some cut short, some scattered bins.
  // Unit-stride runs start near the end of the frame to keep the item count modest.
  task automatic run_segment();
    int start;
    int stride;
    int len;
    int b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        stride = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(3, 12);
        start = (stride == 1) ? $urandom_range(sphb_pkg::NUM_BINS - 32, sphb_pkg::NUM_BINS - 1)
                              : $urandom_range(0, sphb_pkg::NUM_BINS - 1);
        for (b = start; b < sphb_pkg::NUM_BINS - 1; b += stride) send_bin(b, pick_magnitude(b));
        send_bin(sphb_pkg::NUM_BINS - 1, pick_magnitude(sphb_pkg::NUM_BINS - 1));
      end
      6, 7: begin
        start = $urandom_range(0, sphb_pkg::NUM_BINS - 2);
        len = $urandom_range(1, 24);
        stride = $urandom_range(1, 3);
        for (b = start; b < sphb_pkg::NUM_BINS - 1 && len > 0; b += stride) begin
          send_bin(b, pick_magnitude(b));
          len--;
        end
      end
      default: begin
        repeat ($urandom_range(1, 8)) begin
          b = $urandom_range(0, sphb_pkg::NUM_BINS - 1);
          send_bin(b, pick_magnitude(b));
        end
      end
    endcase
  endtask

  // One register setting: random traffic until enough items and at least one frame end.
  task automatic run_phase(int gain, int decay, int gaps, int stalls);
    int first_item;
    int first_frame;
    write_regs(gain, decay);
    gap_pct = gaps;
    stall_pct = stalls;
    first_item = items_sent;
    first_frame = frames_sent;
    while (items_sent - first_item < PHASE_ITEMS || frames_sent == first_frame) run_segment();
    wait_drained();
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sphb_pkg::CFG_GAIN;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.bin_index = '0;
    in_ch.magnitude = '0;
    gap_pct = 15;
    stall_pct = 15;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: saturation, holding at full scale and decay.
    send_bin(0, 0);
    send_bin(0, 65535);
    send_bin(0, 65535);
    send_bin(0, 0);
    send_bin(0, 100);
    // Both sides of every band boundary.
    send_bin(50, 1000);
    send_bin(51, 2000);
    send_bin(101, 1500);
    send_bin(102, 40);
    send_bin(152, 700);
    send_bin(153, 9000);
    send_bin(203, 1);
    send_bin(204, 1200);
    send_bin(254, 65535);
    // Last bin of a frame, then again right after the band maxima were cleared.
    send_bin(255, 65535);
    send_bin(255, 0);
    // Bins out of order.
    send_bin(200, 5000);
    send_bin(10, 300);
    send_bin(254, 0);
    send_bin(255, 1);
    wait_drained();

    // The result side holds off while items keep coming, so the input backs up.
    gap_pct = 0;
    stall_pct = 0;
    long_hold_req = LONG_HOLD;
    for (int b = 0; b < 40; b++) send_bin(b, pick_magnitude(b));
    wait_drained();

    run_phase(0, 0, 20, 20);
    run_phase(65535, 32768, 0, 40);
    run_phase($urandom_range(1, 65535), 65535, 40, 0);
    run_phase($urandom_range(64, 1024), $urandom_range(0, 4000), 15, 15);
    run_phase(sphb_pkg::GAIN_RESET, sphb_pkg::DECAY_RESET, 30, 30);
    // Closing stretch without idling on either side.
    run_phase($urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);

    if (board.errors == 0 && board.expected_levels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (board.expected_levels.size() != 0)
        $display("%0t: %0d expected results never arrived", $time,
                 board.expected_levels.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sphb_pkg.sv
rtl/sphb_in_if.sv
rtl/sphb_out_if.sv
rtl/sphb_ram.sv
rtl/sphb_weight.sv
rtl/sphb_bands.sv
rtl/spectrum_peak_hold_bands_core.sv
dv/spectrum_peak_hold_bands_core_test.sv
